>>> hw/rtl/i2cram_pkg.sv
// ----------------------------------------------------------------------------
// i2cram_pkg
// Shared types and constants for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    // Register indexes on the configuration channel
    localparam logic [1:0] CFG_PHASE_TICKS    = 2'd0;
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd2;

    // Register reset values
    localparam logic [9:0] PHASE_TICKS_RST    = 10'd2;
    localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd56;
    localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Bus phases; the four byte-send groups each hold four sub-phases
    // (data low, data high, ack low, ack high) in consecutive codes.
    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_RS_L, PH_RS_A, PH_RS_B,
        PH_AW_0, PH_AW_1, PH_AW_2, PH_AW_3,
        PH_RG_0, PH_RG_1, PH_RG_2, PH_RG_3,
        PH_DT_0, PH_DT_1, PH_DT_2, PH_DT_3,
        PH_AR_0, PH_AR_1, PH_AR_2, PH_AR_3,
        PH_RX_L, PH_RX_H, PH_MA_L, PH_MA_H,
        PH_SP_L, PH_SP_H, PH_SP_E, PH_SE_L, PH_SE_H, PH_SE_E
    } phase_t;

    // Send group kinds
    localparam logic [1:0] KIND_ADDR_W = 2'd0;
    localparam logic [1:0] KIND_REG    = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_ADDR_R = 2'd3;

    // One input tick item
    typedef struct packed {
        logic       start_cmd;
        logic       opcode;
        logic [7:0] reg_addr;
        logic [7:0] byte_count;
        logic [7:0] wr_data;
        logic       sda_in;
    } item_t;

    // One result item
    typedef struct packed {
        logic       scl;
        logic       sda_pull_low;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       wr_data_taken;
        logic       busy_res;
        logic       done_res;
        logic       error;
    } result_t;

    // Configuration register set
    typedef struct packed {
        logic [9:0] phase_ticks;
        logic [6:0] device_address;
        logic [7:0] ack_timeout;
    } cfg_t;

endpackage

>>> hw/rtl/i2cram_front.sv
// ----------------------------------------------------------------------------
// i2cram_front
// Input side: unpacks stream items and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cram_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // start_cmd, reg_addr, byte_count, wr_data, sda_in
    input  logic                s_tuser,   // opcode
    output logic                q_valid,
    input  logic                q_pop,
    output i2cram_pkg::item_t   q_item
);
    import i2cram_pkg::*;

    item_t      store_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      in_item;
    logic       push;
    logic       pop;

    // Field unpacking
    always_comb
    begin
        in_item.start_cmd  = s_tdata[0];
        in_item.opcode     = s_tuser;
        in_item.reg_addr   = s_tdata[8:1];
        in_item.byte_count = s_tdata[16:9];
        in_item.wr_data    = s_tdata[24:17];
        in_item.sda_in     = s_tdata[25];
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = store_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/i2cram_engine.sv
// ----------------------------------------------------------------------------
// i2cram_engine
// Bus phase engine: advances the I2C sequence one tick per item and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module i2cram_engine
(
    input  logic                clk,
    input  logic                rst_n,
    input  i2cram_pkg::cfg_t    cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cram_pkg::item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output i2cram_pkg::result_t out_result
);
    import i2cram_pkg::*;

    phase_t     phase_reg,   phase_next;
    logic [9:0] tick_reg,    tick_next;
    logic [3:0] bit_reg,     bit_next;
    logic [7:0] shift_reg,   shift_next;
    logic [7:0] left_reg,    left_next;
    logic [7:0] wait_reg,    wait_next;
    logic       opcode_reg,  opcode_next;
    logic [7:0] regsel_reg,  regsel_next;

    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       in_fire;
    logic       taken;
    logic       rdv;
    logic [7:0] rdd;
    logic       done;
    logic       err;
    logic [9:0] pt;
    logic [4:0] sv;
    logic [4:0] off;
    logic [1:0] kind;
    logic [1:0] sub;
    logic       is_tx;
    logic [4:0] nv;
    logic [4:0] noff;

    assign in_ready   = !out_valid_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    // Decode of the current phase
    assign pt    = (cfg.phase_ticks == 10'd0) ? 10'd1 : cfg.phase_ticks;
    assign sv    = phase_reg;
    assign off   = sv - 5'(PH_AW_0);
    assign kind  = off[3:2];
    assign sub   = off[1:0];
    assign is_tx = (sv >= 5'(PH_AW_0)) && (sv < 5'(PH_RX_L));

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        wait_next   = wait_reg;
        opcode_next = opcode_reg;
        regsel_next = regsel_reg;
        taken       = 1'b0;
        rdv         = 1'b0;
        rdd         = 8'd0;
        done        = 1'b0;
        err         = 1'b0;
        if (in_fire)
        begin
            if (phase_reg == PH_IDLE)
            begin
                tick_next = 10'd0;
                if (in_item.start_cmd)
                begin
                    opcode_next = in_item.opcode;
                    regsel_next = in_item.reg_addr;
                    left_next   = (in_item.opcode == OP_READ && in_item.byte_count == 8'd0)
                                  ? 8'd1 : in_item.byte_count;
                    bit_next    = 4'd0;
                    wait_next   = 8'd0;
                    shift_next  = 8'd0;
                    phase_next  = PH_ST_A;
                end
            end
            else if ({1'b0, tick_reg} + 11'd1 < {1'b0, pt})
            begin
                tick_next = tick_reg + 10'd1;
            end
            else
            begin
                tick_next = 10'd0;
                if (is_tx)
                begin
                    // Byte send: data bit phases, then the ACK slot
                    if (sub == 2'd0 || sub == 2'd2)
                    begin
                        phase_next = phase_t'(sv + 5'd1);
                    end
                    else if (sub == 2'd1)
                    begin
                        if (bit_reg >= 4'd7)
                        begin
                            phase_next = phase_t'(sv + 5'd1);
                            wait_next  = 8'd0;
                        end
                        else
                        begin
                            bit_next   = bit_reg + 4'd1;
                            shift_next = {shift_reg[6:0], 1'b0};
                            phase_next = phase_t'(sv - 5'd1);
                        end
                    end
                    else if (in_item.sda_in)
                    begin
                        if (wait_reg >= cfg.ack_timeout)
                        begin
                            phase_next = PH_SE_L;
                        end
                        else
                        begin
                            wait_next = wait_reg + 8'd1;
                        end
                    end
                    else if (kind == KIND_ADDR_W)
                    begin
                        phase_next = PH_RG_0;
                        shift_next = regsel_reg;
                        bit_next   = 4'd0;
                    end
                    else if (kind == KIND_ADDR_R)
                    begin
                        phase_next = PH_RX_L;
                        bit_next   = 4'd0;
                        shift_next = 8'd0;
                    end
                    else if (kind == KIND_REG && opcode_reg == OP_READ)
                    begin
                        phase_next = PH_RS_L;
                    end
                    else if (left_reg != 8'd0)
                    begin
                        phase_next = PH_DT_0;
                        shift_next = in_item.wr_data;
                        bit_next   = 4'd0;
                        left_next  = left_reg - 8'd1;
                        taken      = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SP_L;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_ST_A: phase_next = PH_ST_B;
                        PH_ST_B:
                        begin
                            phase_next = PH_AW_0;
                            shift_next = {cfg.device_address, 1'b0};
                            bit_next   = 4'd0;
                        end
                        PH_RS_L: phase_next = PH_RS_A;
                        PH_RS_A: phase_next = PH_RS_B;
                        PH_RS_B:
                        begin
                            phase_next = PH_AR_0;
                            shift_next = {cfg.device_address, 1'b1};
                            bit_next   = 4'd0;
                        end
                        PH_RX_L: phase_next = PH_RX_H;
                        PH_RX_H:
                        begin
                            // Sample on the last tick of SCL high
                            shift_next = {shift_reg[6:0], in_item.sda_in};
                            if (bit_reg >= 4'd7)
                            begin
                                if (left_reg != 8'd0)
                                begin
                                    left_next = left_reg - 8'd1;
                                end
                                rdv        = 1'b1;
                                rdd        = {shift_reg[6:0], in_item.sda_in};
                                phase_next = PH_MA_L;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 4'd1;
                                phase_next = PH_RX_L;
                            end
                        end
                        PH_MA_L: phase_next = PH_MA_H;
                        PH_MA_H:
                        begin
                            if (left_reg != 8'd0)
                            begin
                                phase_next = PH_RX_L;
                                bit_next   = 4'd0;
                                shift_next = 8'd0;
                            end
                            else
                            begin
                                phase_next = PH_SP_L;
                            end
                        end
                        PH_SP_L: phase_next = PH_SP_H;
                        PH_SP_H: phase_next = PH_SP_E;
                        PH_SE_L: phase_next = PH_SE_H;
                        PH_SE_H: phase_next = PH_SE_E;
                        PH_SP_E:
                        begin
                            done       = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        PH_SE_E:
                        begin
                            done       = 1'b1;
                            err        = 1'b1;
                            phase_next = PH_IDLE;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
        end
    end

    // Bus drive and result fields from the updated state
    assign nv   = phase_next;
    assign noff = nv - 5'(PH_AW_0);

    always_comb
    begin
        res.scl           = 1'b1;
        res.sda_pull_low  = 1'b0;
        res.rd_data       = rdd;
        res.rd_valid      = rdv;
        res.wr_data_taken = taken;
        res.busy_res      = (phase_next != PH_IDLE);
        res.done_res      = done;
        res.error         = done && err;
        if (nv >= 5'(PH_AW_0) && nv < 5'(PH_RX_L))
        begin
            res.scl = noff[0];
            if (!noff[1])
            begin
                res.sda_pull_low = !shift_next[7];
            end
        end
        else
        begin
            case (phase_next)
                PH_ST_B, PH_RS_B, PH_SP_H, PH_SE_H:
                begin
                    res.sda_pull_low = 1'b1;
                end
                PH_RS_L, PH_RX_L:
                begin
                    res.scl = 1'b0;
                end
                PH_SP_L, PH_SE_L:
                begin
                    res.scl          = 1'b0;
                    res.sda_pull_low = 1'b1;
                end
                PH_MA_L:
                begin
                    res.scl          = 1'b0;
                    res.sda_pull_low = (left_next != 8'd0);
                end
                PH_MA_H:
                begin
                    res.sda_pull_low = (left_next != 8'd0);
                end
                default:
                begin
                    res.scl = 1'b1;
                end
            endcase
        end
    end

    // Sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= 10'd0;
            bit_reg    <= 4'd0;
            shift_reg  <= 8'd0;
            left_reg   <= 8'd0;
            wait_reg   <= 8'd0;
            opcode_reg <= 1'b0;
            regsel_reg <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            left_reg   <= left_next;
            wait_reg   <= wait_next;
            opcode_reg <= opcode_next;
            regsel_reg <= regsel_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg <= res;
        end
    end

endmodule

>>> hw/rtl/i2c_register_access_master_core.sv
// ----------------------------------------------------------------------------
// i2c_register_access_master_core
// I2C master running register writes and reads, one bus tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side item is one timing tick: sampled SDA plus an optional
//   start command (opcode in tuser, register, byte count, write data).
//   Each tick gives exactly one master-side item carrying SCL, the SDA
//   pull-low drive, read data strobes, write data take strobes and
//   busy/done/error status after that tick.
//   An item's result passes through the two-entry input queue and then
//   the output register before it is offered on the master side.
//   The block takes one item per clock while the master side is not
//   stalled; the phase engine updates its state once per item, and the
//   output register takes a new result in the same cycle that the
//   previous one is accepted.
//   A stalled master side holds its result; the input queue fills and
//   then drops s_tready until the result is taken.
//   Configuration writes (phase_ticks, device_address, ack_timeout) are
//   taken every cycle and should only be issued while idle.
//   Reset returns the engine to idle with the bus released and restores
//   phase_ticks 2, device_address 56, ack_timeout 250.
// ----------------------------------------------------------------------------
module i2c_register_access_master_core
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [0] start_cmd, [8:1] reg_addr, [16:9] byte_count,
                                   // [24:17] wr_data, [25] sda_in
    input  logic        s_tuser,   // [0] opcode
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl, [1] sda_pull_low, [9:2] rd_data, [10] rd_valid,
                                   // [11] wr_data_taken, [12] busy_res, [13] done_res,
                                   // [14] error
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import i2cram_pkg::*;

    cfg_t    cfg_reg;
    item_t   q_item;
    logic    q_valid;
    logic    q_pop;
    result_t res;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks    <= PHASE_TICKS_RST;
            cfg_reg.device_address <= DEVICE_ADDRESS_RST;
            cfg_reg.ack_timeout    <= ACK_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PHASE_TICKS:    cfg_reg.phase_ticks    <= cfg_data;
                CFG_DEVICE_ADDRESS: cfg_reg.device_address <= cfg_data[6:0];
                CFG_ACK_TIMEOUT:    cfg_reg.ack_timeout    <= cfg_data[7:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Input queue
    i2cram_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // Phase engine
    i2cram_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (q_valid),
        .in_ready   (q_pop),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    // Result packing
    assign m_tdata = {1'b0, res.error, res.done_res, res.busy_res, res.wr_data_taken,
                      res.rd_valid, res.rd_data, res.sda_pull_low, res.scl};

    // An empty output register means the input queue is not full
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input queue full while output register empty");

    // The end of a transaction never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[13]) |-> !m_tdata[12])
        else $error("done reported while still busy");

    // Errors only come with done
    a_error_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[14]) |-> m_tdata[13])
        else $error("error without done");

    // Data strobes only inside a transaction
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[10] || m_tdata[11])) |-> m_tdata[12])
        else $error("data strobe while idle");

endmodule
